@@ design/sles_pkg.sv @@
// Shared types, constants and codes for the sorted leaf entry store.
`default_nettype none

package sles_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int TOT_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        CMD_INSERT      = 3'd0,
        CMD_REMOVE_KEY  = 3'd1,
        CMD_REMOVE_PAIR = 3'd2,
        CMD_SPLIT       = 3'd3,
        CMD_PEEK        = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_BAD_SPLIT = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_e;

    typedef enum logic {
        ST_IDLE,
        ST_SPLIT
    } state_e;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
        logic [31:0]        record_id;
        logic [POS_W-1:0]   split_position;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [31:0]        out_record_id;
        logic [TOT_W-1:0]   entry_total;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        rid;
    } entry_t;

    typedef struct packed {
        cell_op_e           op;
        logic               exact;
        entry_t             fresh;
        logic [CNT_W-1:0]   count;
    } cell_ctrl_t;

    typedef struct packed {
        logic moves;
        logic seen;
    } link_t;

endpackage

`default_nettype wire

@@ design/sorted_leaf_entry_store_unit.sv @@
// Top level of the sorted leaf entry store: command control and the cell chain.
// Holds one sorted leaf node of up to CAPACITY (key, record id) entries.
// A command beat is taken on a rising edge with start high and busy low; its
// fields travel in item. Results appear on result for one cycle, marked by
// strobe, and must be taken then: the receiver has no way to stall them.
// Insert and both removes are done in place: the whole chain shifts at the
// accepting edge, the result is strobed in the next cycle, and busy stays low,
// so one such command is taken every cycle.
// A split or peek with a valid position rotates the chain once per cycle until
// every entry is back in place, strobing the entries from the split position to
// the end, in key order, as they pass cell zero. busy is high while the chain
// rotates, so the next command is taken only after the rotation ends.
// A bad split position, an unused command code, a full node or a failed
// remove gives one result in the next cycle and changes nothing.
// Reset clears the entry count and the control state; entry contents are not
// cleared and are never read before they are written.
`default_nettype none

module sorted_leaf_entry_store_unit (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  sles_pkg::item_t  item,
    output logic             strobe,
    output sles_pkg::result_t result
);
    import sles_pkg::*;

    state_e           state_reg;
    state_e           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] step_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CNT_W-1:0] old_count_reg;
    logic [CNT_W-1:0] old_count_next;
    logic             strobe_reg;
    logic             strobe_next;
    result_t          result_reg;
    result_t          result_next;

    cell_ctrl_t       ctrl;
    entry_t           cell_entry [CAPACITY];
    link_t            cell_link  [CAPACITY];
    logic             accept;
    logic             found;
    logic             bad_split;
    logic [CMP_W-1:0] step_wide;

    assign accept    = start && (state_reg == ST_IDLE);
    assign found     = cell_link[CAPACITY-1].seen;
    assign bad_split = (item.split_position == '0)
                       || (CMP_W'(item.split_position) >= CMP_W'(count_reg));
    assign step_wide = CMP_W'(step_reg);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t left_entry;
            link_t  left_link;
            if (g == 0)
            begin : g_head
                assign left_entry = ctrl.fresh;
                assign left_link  = '0;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[g-1];
                assign left_link  = cell_link[g-1];
            end
            sles_cell u_cell (
                .clk         (clk),
                .idx         (IDX_W'(g)),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_link   (left_link),
                .right_entry (cell_entry[(g + 1) % CAPACITY]),
                .entry       (cell_entry[g]),
                .link        (cell_link[g])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.op        = OP_HOLD;
        ctrl.exact     = (item.command == CMD_REMOVE_PAIR);
        ctrl.fresh.key = item.key;
        ctrl.fresh.rid = item.record_id;
        ctrl.count     = count_reg;
        if (state_reg == ST_SPLIT)
        begin
            ctrl.op = OP_ROTATE;
        end
        else if (start)
        begin
            case (item.command)
                CMD_INSERT:
                begin
                    if (count_reg != CNT_W'(CAPACITY))
                    begin
                        ctrl.op = OP_INSERT;
                    end
                end
                CMD_REMOVE_KEY, CMD_REMOVE_PAIR:
                begin
                    ctrl.op = OP_REMOVE;
                end
                default:
                begin
                    ctrl.op = OP_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        step_next         = step_reg;
        pos_next          = pos_reg;
        old_count_next    = old_count_reg;
        strobe_next       = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next               = 1'b1;
                    result_next.status        = STATUS_OK;
                    result_next.out_key       = '0;
                    result_next.out_record_id = '0;
                    result_next.last          = 1'b1;
                    case (item.command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE_KEY, CMD_REMOVE_PAIR:
                        begin
                            if (found)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                result_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        CMD_SPLIT, CMD_PEEK:
                        begin
                            if (bad_split)
                            begin
                                result_next.status = STATUS_BAD_SPLIT;
                            end
                            else
                            begin
                                strobe_next    = 1'b0;
                                state_next     = ST_SPLIT;
                                step_next      = '0;
                                pos_next       = item.split_position;
                                old_count_next = count_reg;
                                if (item.command == CMD_SPLIT)
                                begin
                                    count_next = CNT_W'(item.split_position);
                                end
                            end
                        end
                        default:
                        begin
                            result_next.status = STATUS_OK;
                        end
                    endcase
                    result_next.entry_total = TOT_W'(count_next);
                end
            end
            ST_SPLIT:
            begin
                step_next = step_reg + 1'b1;
                if ((step_wide >= CMP_W'(pos_reg)) && (step_wide < CMP_W'(old_count_reg)))
                begin
                    strobe_next               = 1'b1;
                    result_next.status        = STATUS_OK;
                    result_next.out_key       = cell_entry[0].key;
                    result_next.out_record_id = cell_entry[0].rid;
                    result_next.entry_total   = TOT_W'(count_reg);
                    result_next.last          = (step_wide == CMP_W'(old_count_reg) - 1'b1);
                end
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            pos_reg       <= '0;
            old_count_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            old_count_reg <= old_count_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.command != CMD_SPLIT) && (item.command != CMD_PEEK)
        |=> strobe && result.last)
        else $error("single-result command did not give one final result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT) && (step_reg != IDX_W'(CAPACITY - 1))
        |=> (state_reg == ST_SPLIT) && (step_reg == IDX_W'($past(step_reg) + 1'b1)))
        else $error("split rotation step did not advance");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("non-final split beat while idle");

endmodule

`default_nettype wire

@@ design/sles_cell.sv @@
// One storage cell of the entry chain: holds one entry and shifts with its neighbors.
`default_nettype none

module sles_cell (
    input  wire                      clk,
    input  wire  [sles_pkg::IDX_W-1:0] idx,
    input  sles_pkg::cell_ctrl_t     ctrl,
    input  sles_pkg::entry_t         left_entry,
    input  sles_pkg::link_t          left_link,
    input  sles_pkg::entry_t         right_entry,
    output sles_pkg::entry_t         entry,
    output sles_pkg::link_t          link
);
    import sles_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   greater;
    logic   match;

    always_comb
    begin
        occupied  = CNT_W'(idx) < ctrl.count;
        greater   = occupied && ($signed(entry_reg.key) > $signed(ctrl.fresh.key));
        match     = occupied && (entry_reg.key == ctrl.fresh.key)
                    && (!ctrl.exact || (entry_reg.rid == ctrl.fresh.rid));
        link.moves = !occupied || greater;
        link.seen  = left_link.seen || match;
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (link.moves)
                begin
                    entry_next = left_link.moves ? left_entry : ctrl.fresh;
                end
            end
            OP_REMOVE:
            begin
                if (link.seen)
                begin
                    entry_next = right_entry;
                end
            end
            OP_ROTATE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
